### hdl/pcfe_pkg.sv
// Shared types and constants for the preamble correlator and frequency estimator.
// No dependencies; imported by pcfe_corr and preamble_correlator_freq_est.
`timescale 1ns / 1ps

package pcfe_pkg;

    localparam int MAG_W      = 22;
    localparam int EST_W      = 40;
    localparam int ACC_W      = 48;
    localparam int EST_SHIFT  = 8;
    localparam int CNT_W      = 16;
    localparam int PAT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int GRP        = 8;

    localparam logic [MAG_W-1:0] THRESH_RESET = MAG_W'(20000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_PATTERN   = 2'd1
    } t_cfg_idx;

endpackage

### hdl/pcfe_corr.sv
// Sample delay line, preamble correlation and conjugate product pipeline.
// Depends on pcfe_pkg; instantiated by preamble_correlator_freq_est.
`timescale 1ns / 1ps

module pcfe_corr #(
    parameter int SYMBOLS            = 32,
    parameter int SAMPLES_PER_SYMBOL = 8,
    parameter int LAG_SYMBOLS        = 16,
    parameter int SAMPLE_WIDTH       = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample_i,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample_q,
    input  logic        [pcfe_pkg::PAT_W-1:0]   i_pattern,
    input  logic        [pcfe_pkg::MAG_W-1:0]   i_threshold,
    output logic                                o_valid,
    input  logic                                i_take,
    output logic signed [SAMPLE_WIDTH-1:0]      o_old_i,
    output logic signed [SAMPLE_WIDTH-1:0]      o_old_q,
    output logic        [pcfe_pkg::MAG_W-1:0]   o_mag,
    output logic                                o_hit,
    output logic signed [pcfe_pkg::ACC_W-1:0]   o_prod_re,
    output logic signed [pcfe_pkg::ACC_W-1:0]   o_prod_im
);
    import pcfe_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int SPS   = SAMPLES_PER_SYMBOL;
    localparam int LEN   = SYMBOLS * SPS;
    localparam int NTAP  = (SPS > 1) ? SYMBOLS : SYMBOLS - 1;
    localparam int NTERM = NTAP + 1;
    localparam int NGRP  = (NTERM + GRP - 1) / GRP;
    localparam int TW    = SW + 1;
    localparam int GSW   = TW + $clog2(GRP);
    localparam int SUMW  = TW + $clog2(NTERM);
    localparam int MW    = SUMW + 1;
    localparam int CW    = (MW > MAG_W) ? MW : MAG_W;
    localparam int PW    = 2 * SW;
    localparam int PSW   = PW + 1;
    localparam int LAGP  = (LAG_SYMBOLS >= SYMBOLS) ? 0 : (SYMBOLS - LAG_SYMBOLS) * SPS - 1;

    logic signed [SW-1:0]   r_dl_i [LEN];
    logic signed [SW-1:0]   r_dl_q [LEN];
    logic                   r_v0, r_v1, r_v2, r_v3;
    logic                   w_adv1, w_adv2, w_adv3, w_accept;

    logic signed [TW-1:0]   w_term_i [NTERM];
    logic signed [TW-1:0]   w_term_q [NTERM];
    logic signed [GSW-1:0]  n_grp_i [NGRP];
    logic signed [GSW-1:0]  n_grp_q [NGRP];
    logic signed [GSW-1:0]  r_grp_i [NGRP];
    logic signed [GSW-1:0]  r_grp_q [NGRP];
    logic signed [PW-1:0]   r_pii, r_pqq, r_piq, r_pqi;
    logic signed [SW-1:0]   r_old1_i, r_old1_q, r_old2_i, r_old2_q;

    logic signed [SUMW-1:0] n_re, n_im, r_re, r_im;
    logic signed [PSW-1:0]  r_pre, r_pim;

    logic        [SUMW-1:0] w_abs_re, w_abs_im;
    logic        [MW-1:0]   w_mag;

    assign w_adv3   = !r_v3 || i_take;
    assign w_adv2   = !r_v2 || w_adv3;
    assign w_adv1   = !r_v1 || w_adv2;
    assign o_ready  = !r_v0 || w_adv1;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_v3;

    // Delay line: position 0 newest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEN; i++) begin
                r_dl_i[i] <= '0;
                r_dl_q[i] <= '0;
            end
        end else if (w_accept) begin
            for (int i = LEN - 1; i > 0; i--) begin
                r_dl_i[i] <= r_dl_i[i-1];
                r_dl_q[i] <= r_dl_q[i-1];
            end
            r_dl_i[0] <= i_sample_i;
            r_dl_q[0] <= i_sample_q;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NTERM; k++) begin : g_term
            localparam int POS = (k < NTAP) ? LEN - 1 - k * SPS : 0;
            localparam int BIT = (k < NTAP) ? SYMBOLS - 1 - k : 0;
            assign w_term_i[k] = i_pattern[BIT] ? TW'(r_dl_i[POS]) : -TW'(r_dl_i[POS]);
            assign w_term_q[k] = i_pattern[BIT] ? TW'(r_dl_q[POS]) : -TW'(r_dl_q[POS]);
        end
    endgenerate

    always_comb begin
        int idx;
        for (int g = 0; g < NGRP; g++) begin
            n_grp_i[g] = '0;
            n_grp_q[g] = '0;
            for (int m = 0; m < GRP; m++) begin
                idx = (g * GRP + m < NTERM) ? g * GRP + m : 0;
                if (g * GRP + m < NTERM) begin
                    n_grp_i[g] = n_grp_i[g] + GSW'(w_term_i[idx]);
                    n_grp_q[g] = n_grp_q[g] + GSW'(w_term_q[idx]);
                end
            end
        end
    end

    always_comb begin
        n_re = '0;
        n_im = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_re = n_re + SUMW'(r_grp_i[g]);
            n_im = n_im + SUMW'(r_grp_q[g]);
        end
    end

    assign w_abs_re = r_re[SUMW-1] ? SUMW'(-r_re) : SUMW'(r_re);
    assign w_abs_im = r_im[SUMW-1] ? SUMW'(-r_im) : SUMW'(r_im);
    assign w_mag    = MW'(w_abs_re) + MW'(w_abs_im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (o_ready) r_v0 <= i_valid;
            if (w_adv1)  r_v1 <= r_v0;
            if (w_adv2)  r_v2 <= r_v1;
            if (w_adv3)  r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            for (int g = 0; g < NGRP; g++) begin
                r_grp_i[g] <= n_grp_i[g];
                r_grp_q[g] <= n_grp_q[g];
            end
            r_pii    <= r_dl_i[LEN-1] * r_dl_i[LAGP];
            r_pqq    <= r_dl_q[LEN-1] * r_dl_q[LAGP];
            r_piq    <= r_dl_i[LEN-1] * r_dl_q[LAGP];
            r_pqi    <= r_dl_q[LEN-1] * r_dl_i[LAGP];
            r_old1_i <= r_dl_i[LEN-1];
            r_old1_q <= r_dl_q[LEN-1];
        end
        if (w_adv2) begin
            r_re     <= n_re;
            r_im     <= n_im;
            r_pre    <= PSW'(r_pii) + PSW'(r_pqq);
            r_pim    <= PSW'(r_piq) - PSW'(r_pqi);
            r_old2_i <= r_old1_i;
            r_old2_q <= r_old1_q;
        end
        if (w_adv3) begin
            o_mag     <= MAG_W'(w_mag);
            o_hit     <= CW'(w_mag) > CW'(i_threshold);
            o_prod_re <= ACC_W'(r_pre);
            o_prod_im <= ACC_W'(r_pim);
            o_old_i   <= r_old2_i;
            o_old_q   <= r_old2_q;
        end
    end

endmodule

### hdl/preamble_correlator_freq_est.sv
// Top level: preamble correlator with conjugate-product frequency estimator.
// Depends on pcfe_pkg and pcfe_corr.
//
// Channel  | Direction | Signals                                  | Content
// s        | in        | i_s_tvalid o_s_tready i_s_tdata          | complex sample
// m        | out       | o_m_tvalid i_m_tready o_m_tdata o_m_tuser | correlation + estimate
// cfg      | in        | i_cfg_valid o_cfg_ready i_cfg_index/data | register write
//
// One sample per cycle sustained while the output is not stalled.
// Each result passes the group adder tree, magnitude compare and accumulator stages.
// Synchronous active-low reset clears the delay lines, counter, accumulators and valid flags.
// A stalled output holds its transaction; input keeps flowing until all stages fill.
`timescale 1ns / 1ps

module preamble_correlator_freq_est #(
    parameter int SYMBOLS            = 32,
    parameter int SAMPLES_PER_SYMBOL = 8,
    parameter int LAG_SYMBOLS        = 16,
    parameter int SAMPLE_WIDTH       = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // tdata: sample_i, sample_q (lowest bits first), zero padded
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    i_s_tdata,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata: delayed_i, delayed_q, magnitude, freq_est_i, freq_est_q, zero padded
    output logic [((2*SAMPLE_WIDTH+pcfe_pkg::MAG_W+2*pcfe_pkg::EST_W+7)/8)*8-1:0] o_m_tdata,
    // tuser: above_threshold, freq_est_valid
    output logic [1:0]                             o_m_tuser,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pcfe_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pcfe_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import pcfe_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int LEN  = SYMBOLS * SAMPLES_PER_SYMBOL;
    localparam int ODW  = ((2*SW + MAG_W + 2*EST_W + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] CNT_MAX  = '1;
    localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(LEN - 1);

    logic [MAG_W-1:0]        r_threshold;
    logic [PAT_W-1:0]        r_pattern;

    logic                    w_c_valid, w_c_hit, w_adv4;
    logic signed [SW-1:0]    w_c_old_i, w_c_old_q;
    logic [MAG_W-1:0]        w_c_mag;
    logic signed [ACC_W-1:0] w_c_pre, w_c_pim;

    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic signed [ACC_W-1:0] r_acc_i, r_acc_q, n_acc_i, n_acc_q;
    logic                    n_est_valid;

    logic                    r_v4;
    logic signed [SW-1:0]    r_old_i, r_old_q;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_hit, r_est_valid;
    logic signed [EST_W-1:0] r_est_i, r_est_q;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
            r_pattern   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data[MAG_W-1:0];
                CFG_PATTERN:   r_pattern   <= i_cfg_data[PAT_W-1:0];
                default:       ;
            endcase
        end
    end

    pcfe_corr #(
        .SYMBOLS            (SYMBOLS),
        .SAMPLES_PER_SYMBOL (SAMPLES_PER_SYMBOL),
        .LAG_SYMBOLS        (LAG_SYMBOLS),
        .SAMPLE_WIDTH       (SAMPLE_WIDTH)
    ) u_corr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_sample_i  (i_s_tdata[SW-1:0]),
        .i_sample_q  (i_s_tdata[2*SW-1:SW]),
        .i_pattern   (r_pattern),
        .i_threshold (r_threshold),
        .o_valid     (w_c_valid),
        .i_take      (w_adv4),
        .o_old_i     (w_c_old_i),
        .o_old_q     (w_c_old_q),
        .o_mag       (w_c_mag),
        .o_hit       (w_c_hit),
        .o_prod_re   (w_c_pre),
        .o_prod_im   (w_c_pim)
    );

    assign w_adv4 = !r_v4 || i_m_tready;

    always_comb begin
        if (w_c_hit) begin
            n_cnt   = '0;
            n_acc_i = w_c_pre;
            n_acc_q = w_c_pim;
        end else begin
            n_cnt   = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CNT_W'(1);
            n_acc_i = r_acc_i + w_c_pre;
            n_acc_q = r_acc_q + w_c_pim;
        end
        n_est_valid = (n_cnt == CNT_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4    <= 1'b0;
            r_cnt   <= '0;
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (w_adv4) begin
            r_v4 <= w_c_valid;
            if (w_c_valid) begin
                r_cnt   <= n_cnt;
                r_acc_i <= n_acc_i;
                r_acc_q <= n_acc_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv4 && w_c_valid) begin
            r_old_i     <= w_c_old_i;
            r_old_q     <= w_c_old_q;
            r_mag       <= w_c_mag;
            r_hit       <= w_c_hit;
            r_est_valid <= n_est_valid;
            r_est_i     <= n_est_valid ? n_acc_i[EST_SHIFT +: EST_W] : '0;
            r_est_q     <= n_est_valid ? n_acc_q[EST_SHIFT +: EST_W] : '0;
        end
    end

    assign o_m_tvalid = r_v4;
    assign o_m_tdata  = ODW'({r_est_q, r_est_i, r_mag, r_old_q, r_old_i});
    assign o_m_tuser  = {r_est_valid, r_hit};

endmodule

### hdl/pcfe_checker.sv
// Port-level assertions for preamble_correlator_freq_est, bound to the top level.
// No package dependency; field positions follow the top level's tdata layout.
`timescale 1ns / 1ps

module pcfe_assertions #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ODW          = 136
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_m_tvalid,
    input logic           i_m_tready,
    input logic [ODW-1:0] o_m_tdata,
    input logic [1:0]     o_m_tuser
);

    localparam int FI_LO = 2 * SAMPLE_WIDTH + 22;
    localparam int FQ_LO = FI_LO + 40;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output transaction changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_hit_no_est: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> !o_m_tuser[1])
        else $error("estimate valid on a hit");

    a_est_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[1] |->
            o_m_tdata[FI_LO +: 40] == '0 && o_m_tdata[FQ_LO +: 40] == '0)
        else $error("estimate fields nonzero while not valid");

    a_est_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tuser[1] |=> !(o_m_tvalid && o_m_tuser[1]))
        else $error("estimate valid on consecutive transactions");

endmodule

bind preamble_correlator_freq_est pcfe_assertions #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ODW          (ODW)
) u_pcfe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

### tb/pcfe_checker.sv
// Checker for preamble_correlator_freq_est: watches the sample, result and register channels,
// predicts each result and compares it field by field. Depends on pcfe_pkg.
`timescale 1ns / 1ps

module pcfe_checker #(
    parameter int SYMBOLS            = 32,
    parameter int SAMPLES_PER_SYMBOL = 8,
    parameter int LAG_SYMBOLS        = 16,
    parameter int SAMPLE_WIDTH       = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]         i_s_tdata,
    input  logic                                        i_s_tvalid,
    input  logic                                        i_s_tready,
    input  logic [((2*SAMPLE_WIDTH+pcfe_pkg::MAG_W+2*pcfe_pkg::EST_W+7)/8)*8-1:0] i_m_tdata,
    input  logic [1:0]                                  i_m_tuser,
    input  logic                                        i_m_tvalid,
    input  logic                                        i_m_tready,
    input  logic                                        i_cfg_valid,
    input  logic                                        i_cfg_ready,
    input  logic [pcfe_pkg::CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [pcfe_pkg::CFG_DATA_W-1:0]             i_cfg_data,
    output int                                          o_backlog,
    output int                                          o_mismatches
);
    import pcfe_pkg::*;

    localparam int SW       = SAMPLE_WIDTH;
    localparam int LINE     = SYMBOLS * SAMPLES_PER_SYMBOL;
    localparam int LAG_RAW  = (SYMBOLS - LAG_SYMBOLS) * SAMPLES_PER_SYMBOL - 1;
    localparam int LAG_TAP  = (LAG_RAW < 0 || LAG_RAW >= LINE) ? 0 : LAG_RAW;
    localparam int MAX_SHOW = 50;

    typedef struct {
        logic signed [SW-1:0]    delayed_i;
        logic signed [SW-1:0]    delayed_q;
        logic [MAG_W-1:0]        magnitude;
        logic                    above;
        logic signed [EST_W-1:0] est_i;
        logic signed [EST_W-1:0] est_q;
        logic                    est_valid;
    } t_corr_result;

    logic signed [SW-1:0] line_i [LINE];
    logic signed [SW-1:0] line_q [LINE];
    logic [CNT_W-1:0]     since_hit;
    logic [ACC_W-1:0]     acc_i;
    logic [ACC_W-1:0]     acc_q;
    logic [MAG_W-1:0]     thresh;
    logic [PAT_W-1:0]     pattern;
    t_corr_result         corr_backlog [$];
    int                   mismatches = 0;

    function automatic t_corr_result correlate(input logic signed [SW-1:0] si,
                                               input logic signed [SW-1:0] sq);
        t_corr_result r;
        longint re, im, vi, vq, mag, oi, oq, li, lq;
        int tap_bit;
        logic hit;
        re = 0;
        im = 0;
        for (int j = LINE - 1; j > 0; j--) begin
            line_i[j] = line_i[j-1];
            line_q[j] = line_q[j-1];
        end
        line_i[0] = si;
        line_q[0] = sq;
        tap_bit = SYMBOLS - 1;
        for (int j = LINE - 1; j > 0 && tap_bit >= 0; j -= SAMPLES_PER_SYMBOL) begin
            vi = line_i[j];
            vq = line_q[j];
            re += pattern[tap_bit] ? vi : -vi;
            im += pattern[tap_bit] ? vq : -vq;
            tap_bit--;
        end
        vi = line_i[0];
        vq = line_q[0];
        re += pattern[0] ? vi : -vi;
        im += pattern[0] ? vq : -vq;
        mag = (re < 0 ? -re : re) + (im < 0 ? -im : im);
        hit = mag > longint'(thresh);
        if (hit) begin
            since_hit = '0;
            acc_i = '0;
            acc_q = '0;
        end else if (since_hit != {CNT_W{1'b1}}) begin
            since_hit = since_hit + 1'b1;
        end
        oi = line_i[LINE-1];
        oq = line_q[LINE-1];
        li = line_i[LAG_TAP];
        lq = line_q[LAG_TAP];
        acc_i = acc_i + ACC_W'(oi * li + oq * lq);
        acc_q = acc_q + ACC_W'(oi * lq - oq * li);
        r.delayed_i = line_i[LINE-1];
        r.delayed_q = line_q[LINE-1];
        r.magnitude = MAG_W'(mag);
        r.above     = hit;
        r.est_valid = (since_hit == CNT_W'(LINE - 1));
        r.est_i     = r.est_valid ? acc_i[EST_SHIFT +: EST_W] : '0;
        r.est_q     = r.est_valid ? acc_q[EST_SHIFT +: EST_W] : '0;
        return r;
    endfunction

    function automatic int field_diff(input string name, input longint want, input longint got);
        if (want == got)
            return 0;
        if (mismatches < MAX_SHOW)
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_corr_result want;
        t_corr_result got;
        if (!i_rst_n) begin
            thresh    = THRESH_RESET;
            pattern   = '0;
            since_hit = '0;
            acc_i     = '0;
            acc_q     = '0;
            for (int k = 0; k < LINE; k++) begin
                line_i[k] = '0;
                line_q[k] = '0;
            end
            corr_backlog.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: thresh = i_cfg_data[MAG_W-1:0];
                    CFG_PATTERN:   pattern = i_cfg_data[PAT_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                corr_backlog.push_back(correlate(i_s_tdata[0 +: SW], i_s_tdata[SW +: SW]));
            if (i_m_tvalid && i_m_tready) begin
                got.delayed_i = i_m_tdata[0 +: SW];
                got.delayed_q = i_m_tdata[SW +: SW];
                got.magnitude = i_m_tdata[2*SW +: MAG_W];
                got.est_i     = i_m_tdata[2*SW+MAG_W +: EST_W];
                got.est_q     = i_m_tdata[2*SW+MAG_W+EST_W +: EST_W];
                got.above     = i_m_tuser[0];
                got.est_valid = i_m_tuser[1];
                if (corr_backlog.size() == 0) begin
                    if (mismatches < MAX_SHOW)
                        $display("%0t: unexpected transaction, expected none actual %h",
                                 $time, i_m_tdata);
                    mismatches++;
                end else begin
                    want = corr_backlog.pop_front();
                    mismatches += field_diff("delayed_i", want.delayed_i, got.delayed_i);
                    mismatches += field_diff("delayed_q", want.delayed_q, got.delayed_q);
                    mismatches += field_diff("magnitude", want.magnitude, got.magnitude);
                    mismatches += field_diff("above_threshold", want.above, got.above);
                    mismatches += field_diff("freq_est_i", want.est_i, got.est_i);
                    mismatches += field_diff("freq_est_q", want.est_q, got.est_q);
                    mismatches += field_diff("freq_est_valid", want.est_valid, got.est_valid);
                end
            end
        end
        o_backlog    <= corr_backlog.size();
        o_mismatches <= mismatches;
    end

endmodule

### tb/tb.sv
// Testbench top for preamble_correlator_freq_est: drives samples, register writes and
// output stalls, and gives the verdict. Depends on pcfe_pkg and pcfe_checker.
`timescale 1ns / 1ps

module tb;
    import pcfe_pkg::*;

    localparam int SYM         = 32;
    localparam int SPS         = 8;
    localparam int LAG         = 16;
    localparam int SW          = 16;
    localparam int S_W         = ((2*SW+7)/8)*8;
    localparam int M_W         = ((2*SW+MAG_W+2*EST_W+7)/8)*8;
    localparam int LINE        = SYM * SPS;
    localparam int STALL_LEN   = 100;
    localparam int STUCK_LIMIT = 2000;
    localparam int NOISE_AMP   = 100;
    localparam int THR_LO      = 8000;
    localparam int THR_HI      = 300000;
    localparam int MAG_TOP     = 2162688;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam logic signed [SW-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SW-1:0] S_MIN = 16'sh8000;
    localparam logic signed [SW-1:0] S_ONE = 16'sd1;
    localparam logic signed [SW-1:0] S_NEG = -16'sd1;
    localparam logic signed [SW-1:0] S_ZERO = 16'sd0;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic [S_W-1:0]        i_s_tdata   = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [M_W-1:0]        o_m_tdata;
    logic [1:0]            o_m_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int             backlog;
    int             mismatches;
    int             items_sent     = 0;
    int             sink_hold      = 0;
    int             stuck          = 0;
    logic           quiet          = 1'b0;
    logic           long_hold_req  = 1'b0;
    logic           long_hold_done = 1'b0;
    logic [PAT_W-1:0] tap_pattern  = '0;

    always #1 i_clk = ~i_clk;

    preamble_correlator_freq_est u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    pcfe_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tdata    (i_s_tdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_backlog    (backlog),
        .o_mismatches (mismatches)
    );

    // Output side: short random stalls, one long hold to back up the pipeline.
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold  <= sink_hold - 1;
            i_m_tready <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done <= 1'b1;
            sink_hold      <= STALL_LEN - 1;
            i_m_tready     <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            sink_hold  <= $urandom_range(0, 2);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck <= 0;
        end else if (stuck == STUCK_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    function automatic logic signed [SW-1:0] noise_sample();
        return SW'(int'($urandom_range(0, 2*NOISE_AMP)) - NOISE_AMP);
    endfunction

    task automatic send_sample(input logic signed [SW-1:0] si, input logic signed [SW-1:0] sq);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_W'({sq, si});
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic retune(input logic [CFG_DATA_W-1:0] thr_word, input logic [PAT_W-1:0] pat);
        write_reg(CFG_THRESHOLD, thr_word);
        write_reg(CFG_PATTERN, pat);
        i_cfg_valid <= 1'b0;
        tap_pattern = pat;
    endtask

    // Drop valid and wait until every predicted result has come out.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (backlog != 0) @(posedge i_clk);
    endtask

    task automatic send_edges();
        send_sample(S_ZERO, S_ZERO);
        send_sample(S_MIN, S_MIN);
        send_sample(S_MAX, S_MAX);
        send_sample(S_MIN, S_MAX);
        send_sample(S_MAX, S_MIN);
        send_sample(S_NEG, S_NEG);
        send_sample(S_ONE, S_ONE);
        send_sample(S_ZERO, S_MIN);
    endtask

    // Mostly preambles followed by quiet tails, with truncated preambles and
    // full-scale noise bursts mixed in.
    task automatic run_traffic(input int count);
        int stop_at;
        int syms;
        logic signed [SW-1:0] amp_i;
        logic signed [SW-1:0] amp_q;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(10, 60)) send_sample(SW'($urandom), SW'($urandom));
            end else begin
                amp_i = SW'($urandom);
                amp_q = SW'($urandom);
                syms  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, SYM - 1) : SYM;
                for (int s = 0; s < syms; s++) begin
                    repeat (SPS)
                        send_sample(tap_pattern[SYM-1-s] ? amp_i : -amp_i,
                                    tap_pattern[SYM-1-s] ? amp_q : -amp_q);
                end
                repeat ($urandom_range(LINE - 56, LINE + 64))
                    send_sample(noise_sample(), noise_sample());
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_edges();
        settle();
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, '1);
        retune(32'hFFC0_0000, '1);
        send_edges();
        settle();
        retune(CFG_DATA_W'(MAG_TOP), 32'hAAAA_5555);
        send_edges();

        for (int p = 0; p < 4; p++) begin
            settle();
            retune($urandom_range(THR_LO, THR_HI), p == 1 ? 32'h0 : 32'($urandom));
            if (p == 1)
                long_hold_req <= 1'b1;
            if (p == 3)
                quiet <= 1'b1;
            run_traffic(200);
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && backlog == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
